/* sv/ght_pkg.sv */
// Shared types and fixed constants of the generational handle table.
// Used by ght_update and generational_handle_table; depends on nothing.
`default_nettype none

package ght_pkg;

    // Slot count and handle layout are fixed: a handle is {generation, slot index}.
    localparam int SLOT_BITS   = 6;
    localparam int NUM_SLOTS   = 1 << SLOT_BITS;
    localparam int HANDLE_BITS = 38;
    localparam int HGEN_BITS   = HANDLE_BITS - SLOT_BITS;
    localparam int OBJ_BITS    = 64;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;
    localparam int STATE_BITS  = 3;
    localparam int TDATA_BITS  = 104;

    typedef enum logic [OP_BITS-1:0] {
        OP_ALLOC     = 3'd0,
        OP_FREE      = 3'd1,
        OP_SET_FILE  = 3'd2,
        OP_SET_DIR   = 3'd3,
        OP_UNSET     = 3'd4,
        OP_BEGIN_USE = 3'd5,
        OP_END_USE   = 3'd6
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        S_OK    = 3'd0,
        S_FULL  = 3'd1,
        S_STALE = 3'd2,
        S_STATE = 3'd3,
        S_COUNT = 3'd4
    } status_t;

    typedef enum logic [STATE_BITS-1:0] {
        SL_FREE      = 3'd0,
        SL_ALLOC     = 3'd1,
        SL_OPEN_FILE = 3'd2,
        SL_OPEN_DIR  = 3'd3,
        SL_BUSY_FILE = 3'd4,
        SL_BUSY_DIR  = 3'd5
    } slot_state_t;

    // Decision of the update logic for one request.
    typedef struct packed {
        status_t status;
        logic    meta_we;
        logic    obj_we;
        logic    obj_clear;
        logic    obj_out_en;
        logic    newh_en;
    } upd_ctl_t;

endpackage

`default_nettype wire

/* sv/ght_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for every memory of the handle table.
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ght_update.sv */
// Per-request slot update: checks generation and slot state, builds the new entry.
// Depends on ght_pkg for operation, status and slot state codes.
`default_nettype none

module ght_update #(
    parameter int GEN_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire ght_pkg::op_t                   op,
    input  wire logic                           found,
    input  wire logic [ght_pkg::HGEN_BITS-1:0]  hgen,
    input  wire ght_pkg::slot_state_t           cur_state,
    input  wire logic [GEN_BITS-1:0]            cur_gen,
    input  wire logic [COUNT_BITS-1:0]          cur_count,
    output ght_pkg::upd_ctl_t                   ctl,
    output ght_pkg::slot_state_t                nxt_state,
    output logic      [GEN_BITS-1:0]            nxt_gen,
    output logic      [COUNT_BITS-1:0]          nxt_count
);

    localparam int CMP_BITS = (GEN_BITS > ght_pkg::HGEN_BITS) ? GEN_BITS : ght_pkg::HGEN_BITS;

    logic stale;
    logic is_open;
    logic is_busy;
    logic cnt_full;
    logic [COUNT_BITS-1:0] cnt_dec;

    // A handle from an older generation than the slot's is refused.
    assign stale    = CMP_BITS'(hgen) < CMP_BITS'(cur_gen);
    assign is_open  = (cur_state == ght_pkg::SL_OPEN_FILE) || (cur_state == ght_pkg::SL_OPEN_DIR);
    assign is_busy  = (cur_state == ght_pkg::SL_BUSY_FILE) || (cur_state == ght_pkg::SL_BUSY_DIR);
    assign cnt_full = &cur_count;
    assign cnt_dec  = cur_count - COUNT_BITS'(1);

    // Operation decode and new slot entry.
    always_comb
    begin
        ctl            = '0;
        ctl.status     = ght_pkg::S_OK;
        nxt_state      = cur_state;
        nxt_gen        = cur_gen;
        nxt_count      = cur_count;
        if (op == ght_pkg::OP_ALLOC)
        begin
            if (found)
            begin
                nxt_state   = ght_pkg::SL_ALLOC;
                ctl.meta_we = 1'b1;
                ctl.newh_en = 1'b1;
            end
            else
            begin
                ctl.status = ght_pkg::S_FULL;
            end
        end
        else if (stale && (op != ght_pkg::OP_ALLOC) && (op <= ght_pkg::OP_END_USE))
        begin
            ctl.status = ght_pkg::S_STALE;
        end
        else
        begin
            case (op)
                ght_pkg::OP_FREE:
                begin
                    if (cur_state == ght_pkg::SL_ALLOC)
                    begin
                        nxt_state   = ght_pkg::SL_FREE;
                        nxt_gen     = cur_gen + GEN_BITS'(1);
                        ctl.meta_we = 1'b1;
                    end
                    else
                    begin
                        ctl.status = ght_pkg::S_STATE;
                    end
                end
                ght_pkg::OP_SET_FILE, ght_pkg::OP_SET_DIR:
                begin
                    if (cur_state == ght_pkg::SL_ALLOC)
                    begin
                        nxt_state   = (op == ght_pkg::OP_SET_FILE) ? ght_pkg::SL_OPEN_FILE
                                                                   : ght_pkg::SL_OPEN_DIR;
                        ctl.meta_we = 1'b1;
                        ctl.obj_we  = 1'b1;
                    end
                    else
                    begin
                        ctl.status = ght_pkg::S_STATE;
                    end
                end
                ght_pkg::OP_UNSET:
                begin
                    if (is_open)
                    begin
                        nxt_state     = ght_pkg::SL_ALLOC;
                        ctl.meta_we   = 1'b1;
                        ctl.obj_we    = 1'b1;
                        ctl.obj_clear = 1'b1;
                    end
                    else
                    begin
                        ctl.status = ght_pkg::S_STATE;
                    end
                end
                ght_pkg::OP_BEGIN_USE:
                begin
                    if (is_open)
                    begin
                        nxt_state      = (cur_state == ght_pkg::SL_OPEN_FILE)
                                         ? ght_pkg::SL_BUSY_FILE : ght_pkg::SL_BUSY_DIR;
                        nxt_count      = COUNT_BITS'(1);
                        ctl.meta_we    = 1'b1;
                        ctl.obj_out_en = 1'b1;
                    end
                    else if (is_busy)
                    begin
                        if (cnt_full)
                        begin
                            ctl.status = ght_pkg::S_COUNT;
                        end
                        else
                        begin
                            nxt_count      = cur_count + COUNT_BITS'(1);
                            ctl.meta_we    = 1'b1;
                            ctl.obj_out_en = 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.status = ght_pkg::S_STATE;
                    end
                end
                ght_pkg::OP_END_USE:
                begin
                    if (is_busy)
                    begin
                        nxt_count   = cnt_dec;
                        ctl.meta_we = 1'b1;
                        if (cnt_dec == '0)
                        begin
                            nxt_state = (cur_state == ght_pkg::SL_BUSY_FILE)
                                        ? ght_pkg::SL_OPEN_FILE : ght_pkg::SL_OPEN_DIR;
                        end
                    end
                    else
                    begin
                        ctl.status = ght_pkg::S_STATE;
                    end
                end
                default:
                begin
                    // Undefined operation code: nothing changes.
                    ctl.status = ght_pkg::S_STATE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/generational_handle_table.sv */
// Generational handle table: 64 slots of {state, generation, use count, object}.
// Depends on ght_pkg, ght_ram and ght_update.
//
// Usage
//   Requests arrive on the s_ channel, one word each; the operation code rides on
//   s_tuser, the handle and object reference on s_tdata. Every request gives
//   exactly one result word on the m_ channel: the status on m_tuser, the new
//   handle and returned object reference on m_tdata (zero where not produced).
//   A request is a read-modify-write of one entry: the accepting edge reads the
//   slot entry from the slot memories (registered read); a later edge, once the
//   result register is empty or being taken, writes the updated entry back and
//   loads the result register. s_tready then rises again, so no request is taken
//   before the last is written back. Allocation picks the lowest free slot from a
//   free bitmap through a priority encoder in the accepting cycle.
//   The result register holds a finished word while the receiver stalls; a
//   request already read then waits in place and no further request is taken.
//   Reset leaves the reserved low slots allocated, the rest free, and every
//   generation zero; per-slot written flags stand in for the memory contents
//   until a slot is first written, so no clearing pass is needed.
`default_nettype none

module generational_handle_table #(
    parameter int RESERVED_SLOTS = 3,
    parameter int GEN_BITS       = 32,
    parameter int COUNT_BITS     = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Request channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: handle_number [37:0], object_ref [101:38], zero [103:102]
    input  wire logic [ght_pkg::TDATA_BITS-1:0]    s_tdata,
    // s_tuser: operation [2:0]
    input  wire logic [ght_pkg::OP_BITS-1:0]       s_tuser,
    // Result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: new_handle [37:0], object_out [101:38], zero [103:102]
    output logic      [ght_pkg::TDATA_BITS-1:0]    m_tdata,
    // m_tuser: status [2:0]
    output logic      [ght_pkg::STATUS_BITS-1:0]   m_tuser
);

    localparam int SB       = ght_pkg::SLOT_BITS;
    localparam int NS       = ght_pkg::NUM_SLOTS;
    localparam int META_W   = ght_pkg::STATE_BITS + GEN_BITS + COUNT_BITS;
    localparam int CMP_BITS = (GEN_BITS > ght_pkg::HGEN_BITS) ? GEN_BITS : ght_pkg::HGEN_BITS;
    localparam int PAD_BITS = ght_pkg::TDATA_BITS - ght_pkg::HANDLE_BITS - ght_pkg::OBJ_BITS;

    // Request in flight.
    logic                               busy_reg, busy_next;
    ght_pkg::op_t                       op_reg;
    logic [ght_pkg::HGEN_BITS-1:0]      hgen_reg;
    logic [ght_pkg::OBJ_BITS-1:0]       obj_reg;
    logic [SB-1:0]                      addr_reg;
    logic                               found_reg;

    // Result register.
    logic                               m_valid_reg, m_valid_next;
    ght_pkg::status_t                   status_reg;
    logic [ght_pkg::HANDLE_BITS-1:0]    newh_reg;
    logic [ght_pkg::OBJ_BITS-1:0]       oout_reg;

    // Free bitmap and written flags.
    logic [NS-1:0]                      free_reg;
    logic [NS-1:0]                      written_reg;

    logic                               accept;
    logic                               wb;
    ght_pkg::op_t                       in_op;
    logic [SB-1:0]                      alloc_idx;
    logic                               any_free;
    logic [SB-1:0]                      rd_addr;

    logic [META_W-1:0]                  meta_rdata, meta_wdata;
    logic [ght_pkg::OBJ_BITS-1:0]       obj_rdata, obj_wdata;

    ght_pkg::slot_state_t               cur_state, nxt_state;
    logic [GEN_BITS-1:0]                cur_gen, nxt_gen;
    logic [COUNT_BITS-1:0]              cur_count, nxt_count;
    ght_pkg::upd_ctl_t                  ctl;
    logic [CMP_BITS-1:0]                gen_ext;

    assign in_op    = ght_pkg::op_t'(s_tuser);
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign wb       = busy_reg && (!m_valid_reg || m_tready);

    // Lowest free slot.
    always_comb
    begin
        alloc_idx = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc_idx = SB'(i);
            end
        end
    end

    assign any_free = |free_reg;
    assign rd_addr  = (in_op == ght_pkg::OP_ALLOC) ? alloc_idx : s_tdata[SB-1:0];

    // Slot memories: {count, generation, state} and the object reference.
    ght_ram #(
        .WIDTH (META_W),
        .DEPTH (NS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (wb && ctl.meta_we),
        .waddr (addr_reg),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (meta_rdata)
    );

    ght_ram #(
        .WIDTH (ght_pkg::OBJ_BITS),
        .DEPTH (NS)
    ) u_obj_ram (
        .clk   (clk),
        .we    (wb && ctl.obj_we),
        .waddr (addr_reg),
        .wdata (obj_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (obj_rdata)
    );

    // An entry never written reads its state and generation as their reset values.
    always_comb
    begin
        if (written_reg[addr_reg])
        begin
            cur_state = ght_pkg::slot_state_t'(meta_rdata[ght_pkg::STATE_BITS-1:0]);
            cur_gen   = meta_rdata[ght_pkg::STATE_BITS +: GEN_BITS];
        end
        else
        begin
            cur_state = (int'(addr_reg) < RESERVED_SLOTS) ? ght_pkg::SL_ALLOC : ght_pkg::SL_FREE;
            cur_gen   = '0;
        end
        cur_count = meta_rdata[ght_pkg::STATE_BITS + GEN_BITS +: COUNT_BITS];
    end

    ght_update #(
        .GEN_BITS   (GEN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .op        (op_reg),
        .found     (found_reg),
        .hgen      (hgen_reg),
        .cur_state (cur_state),
        .cur_gen   (cur_gen),
        .cur_count (cur_count),
        .ctl       (ctl),
        .nxt_state (nxt_state),
        .nxt_gen   (nxt_gen),
        .nxt_count (nxt_count)
    );

    assign meta_wdata = {nxt_count, nxt_gen, nxt_state};
    assign obj_wdata  = ctl.obj_clear ? '0 : obj_reg;
    assign gen_ext    = CMP_BITS'(cur_gen);

    // Handshake control.
    always_comb
    begin
        busy_next = busy_reg;
        if (wb)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (wb)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            written_reg <= '0;
            for (int i = 0; i < NS; i++)
            begin
                free_reg[i] <= (i >= RESERVED_SLOTS);
            end
        end
        else
        begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            if (wb && ctl.meta_we)
            begin
                written_reg[addr_reg] <= 1'b1;
                free_reg[addr_reg]    <= (nxt_state == ght_pkg::SL_FREE);
            end
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            hgen_reg  <= s_tdata[ght_pkg::HANDLE_BITS-1:SB];
            obj_reg   <= s_tdata[ght_pkg::HANDLE_BITS +: ght_pkg::OBJ_BITS];
            addr_reg  <= rd_addr;
            found_reg <= any_free;
        end
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        if (wb)
        begin
            status_reg <= ctl.status;
            newh_reg   <= ctl.newh_en ? {gen_ext[ght_pkg::HGEN_BITS-1:0], addr_reg} : '0;
            oout_reg   <= ctl.obj_out_en ? obj_rdata : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, oout_reg, newh_reg};

    // A successful allocation always lands on a slot that was free.
    a_alloc_free : assert property (@(posedge clk) disable iff (!rst_n)
        (wb && op_reg == ght_pkg::OP_ALLOC && ctl.status == ght_pkg::S_OK)
        |-> (cur_state == ght_pkg::SL_FREE))
        else $error("allocation picked a slot that is not free");

    // After a successful free the slot is back in the free bitmap.
    a_free_bitmap : assert property (@(posedge clk) disable iff (!rst_n)
        (wb && op_reg == ght_pkg::OP_FREE && ctl.meta_we)
        |=> free_reg[$past(addr_reg)])
        else $error("freed slot missing from free bitmap");

    // Table full is reported only when no slot is free.
    a_full_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (wb && ctl.status == ght_pkg::S_FULL) |-> (free_reg == '0))
        else $error("table full reported while a slot is free");

endmodule

`default_nettype wire
